@@ hw/rtl/lap_pkg.sv @@
// shared constants, types and helpers of the laplacian edge filter
package lap_pkg;

   localparam int PIX_W          = 8;
   localparam int CFG_W          = 10;
   localparam int BIAS_W         = 8;
   localparam int ROW_W          = 10;
   localparam int POS_W          = 20;
   localparam int CSR_ADDR_W     = 2;
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;

   localparam logic [CFG_W-1:0]  LINE_WIDTH_RST   = 10'd352;
   localparam logic [CFG_W-1:0]  FRAME_HEIGHT_RST = 10'd288;
   localparam logic [BIAS_W-1:0] BIAS_RST         = 8'd127;

   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_WIDTH   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BIAS         = 2'd2;

   // per-request info carried from the counter stage to the window stage
   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             emit;
      logic             up_ok;
      logic             down_ok;
      logic             left_ok;
      logic             right_ok;
      logic             last;
   } lap_stage_type;

   // frame dimension limited to 1..maxv
   function automatic logic [CFG_W-1:0] clamp_dim(logic [CFG_W-1:0] raw, int unsigned maxv);
      logic [CFG_W-1:0] res;
      if (raw == '0) begin
         res = CFG_W'(1);
      end else if (32'(raw) > maxv) begin
         res = CFG_W'(maxv);
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/lap_ram.sv @@
// generic single-port-write ram with registered read
module lap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/lap_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module lap_div #(
   parameter int NUM_W = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUM_W-1:0]        dividend,
   input  logic [lap_pkg::CFG_W-1:0] divisor,
   output logic                    busy,
   output logic [NUM_W-1:0]        quotient,
   output logic [lap_pkg::CFG_W-1:0] remainder
);

   import lap_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_W-1:0]     quot_ff, quot_in;
   logic [CFG_W-1:0]     rem_ff, rem_in;
   logic [CFG_W:0]       rem_sh;
   logic [CFG_W:0]       rem_sub;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      rem_sh  = {rem_ff, quot_ff[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, divisor};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quot_in = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, divisor}) begin
            rem_in  = rem_sub[CFG_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[CFG_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

@@ hw/rtl/lap_ctrl.sv @@
// configuration registers, frame position counters and request intake
module lap_ctrl #(
   parameter int MAX_WIDTH  = lap_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lap_pkg::MAX_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [lap_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [lap_pkg::CFG_W-1:0]          csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lap_pkg::PIX_W-1:0]          req_tdata,
   input  logic                               req_tuser,
   input  logic                               stage_free,
   output logic                               load,
   output lap_pkg::lap_stage_type             stage,
   output logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
   output logic [lap_pkg::BIAS_W-1:0]         bias
);

   import lap_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EFF_W = (MAX_WIDTH < 1023) ? MAX_WIDTH : 1023;
   localparam int EFF_H = (MAX_HEIGHT < 1023) ? MAX_HEIGHT : 1023;
   localparam int CNT_W = $clog2(EFF_W * EFF_H);
   localparam int TOT_W = CNT_W + 1;

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_TOTAL = 2'd1;
   localparam logic [1:0] ST_POS   = 2'd2;
   localparam logic [1:0] ST_DIV   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CFG_W-1:0]  width_ff, width_in;
   logic [CFG_W-1:0]  height_ff, height_in;
   logic [BIAS_W-1:0] bias_ff, bias_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  emit_cnt_ff, emit_cnt_in;
   logic [CNT_W-1:0]  prow_ff, prow_in;
   logic [COL_W-1:0]  pcol_ff, pcol_in;

   logic              accept;
   logic              draining;
   logic              col_wrap;
   logic              pcol_wrap;
   logic [2*CFG_W-1:0] area_prod;
   logic [2*CFG_W-1:0] row_prod;
   logic              div_start;
   logic              div_busy;
   logic [CNT_W-1:0]  div_quot;
   logic [CFG_W-1:0]  div_rem;

   lap_div #(.NUM_W(CNT_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (emit_cnt_ff),
      .divisor   (width_ff),
      .busy      (div_busy),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign req_tready = (state_ff == ST_RUN) && stage_free;
   assign accept     = req_tvalid && req_tready;
   assign draining   = pos_ff >= POS_W'(total_ff);
   // a flush while pixels are still due is dropped with no effect
   assign load       = accept && !(req_tuser && !draining);
   assign rd_addr    = col_ff;
   assign bias       = bias_ff;
   assign div_start  = (state_ff == ST_TOTAL);

   assign area_prod = {{CFG_W{1'b0}}, width_ff} * {{CFG_W{1'b0}}, height_ff};
   assign row_prod  = {{CFG_W{1'b0}}, row_ff} * {{CFG_W{1'b0}}, width_ff};

   assign col_wrap  = (32'(col_ff) + 32'd1) >= 32'(width_ff);
   assign pcol_wrap = (32'(pcol_ff) + 32'd1) >= 32'(width_ff);

   always_comb begin
      stage.pix      = draining ? '0 : req_tdata;
      stage.emit     = pos_ff >= (POS_W'(width_ff) + POS_W'(1));
      stage.up_ok    = prow_ff != '0;
      stage.down_ok  = (32'(prow_ff) + 32'd1) < 32'(height_ff);
      stage.left_ok  = pcol_ff != '0;
      stage.right_ok = !pcol_wrap;
      stage.last     = (32'(emit_cnt_ff) + 32'd1) >= 32'(total_ff);
   end

   always_comb begin
      state_in    = state_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      bias_in     = bias_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      pos_in      = pos_ff;
      total_in    = total_ff;
      emit_cnt_in = emit_cnt_ff;
      prow_in     = prow_ff;
      pcol_in     = pcol_ff;

      // recompute derived counters after reset or a dimension change
      case (state_ff)
         ST_RUN: begin
         end
         ST_TOTAL: begin
            total_in = TOT_W'(area_prod);
            state_in = ST_POS;
         end
         ST_POS: begin
            pos_in   = POS_W'(row_prod) + POS_W'(col_ff);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!div_busy) begin
               prow_in  = div_quot;
               pcol_in  = COL_W'(div_rem);
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_TOTAL;
         end
      endcase

      if (load) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
            if (row_ff == {ROW_W{1'b1}}) begin
               pos_in = '0;
            end else begin
               pos_in = pos_ff - POS_W'(col_ff) + POS_W'(width_ff);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
            pos_in = pos_ff + POS_W'(1);
         end
         if (stage.emit) begin
            if (stage.last) begin
               col_in      = '0;
               row_in      = '0;
               pos_in      = '0;
               emit_cnt_in = '0;
               prow_in     = '0;
               pcol_in     = '0;
            end else begin
               emit_cnt_in = emit_cnt_ff + CNT_W'(1);
               if (pcol_wrap) begin
                  pcol_in = '0;
                  prow_in = prow_ff + CNT_W'(1);
               end else begin
                  pcol_in = pcol_ff + COL_W'(1);
               end
            end
         end
      end

      if (csr_we) begin
         case (csr_addr)
            CSR_LINE_WIDTH: begin
               width_in = clamp_dim(csr_wdata, MAX_WIDTH);
               state_in = ST_TOTAL;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = clamp_dim(csr_wdata, MAX_HEIGHT);
               state_in  = ST_TOTAL;
            end
            CSR_BIAS: begin
               bias_in = csr_wdata[BIAS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_TOTAL;
         width_ff    <= clamp_dim(LINE_WIDTH_RST, MAX_WIDTH);
         height_ff   <= clamp_dim(FRAME_HEIGHT_RST, MAX_HEIGHT);
         bias_ff     <= BIAS_RST;
         col_ff      <= '0;
         row_ff      <= '0;
         pos_ff      <= '0;
         total_ff    <= '0;
         emit_cnt_ff <= '0;
         prow_ff     <= '0;
         pcol_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         bias_ff     <= bias_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         pos_ff      <= pos_in;
         total_ff    <= total_in;
         emit_cnt_ff <= emit_cnt_in;
         prow_ff     <= prow_in;
         pcol_ff     <= pcol_in;
      end
   end

endmodule

@@ hw/rtl/lap_window.sv @@
// window stage: line buffer update, laplacian sum, clamp and output register
module lap_window #(
   parameter int MAX_WIDTH = lap_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  lap_pkg::lap_stage_type        stage,
   input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
   input  logic [lap_pkg::BIAS_W-1:0]    bias,
   input  logic [lap_pkg::PIX_W-1:0]     upper_q,
   input  logic [lap_pkg::PIX_W-1:0]     middle_q,
   output logic                          stage_free,
   output logic                          wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   output logic [lap_pkg::PIX_W-1:0]     wr_upper,
   output logic [lap_pkg::PIX_W-1:0]     wr_middle,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lap_pkg::PIX_W-1:0]     rsp_tdata,   // filtered
   output logic                          rsp_tlast
);

   import lap_pkg::*;

   localparam int ADDR_W = $clog2(MAX_WIDTH);

   logic               s1_valid_ff, s1_valid_in;
   lap_stage_type      s1_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic               byp_ff, byp_in;
   logic [PIX_W-1:0]   byp_upper_ff;
   logic [PIX_W-1:0]   byp_middle_ff;
   logic [PIX_W-1:0]   c1_mid_ff;
   logic [PIX_W-1:0]   c2_top_ff, c2_mid_ff, c2_bot_ff;
   logic               out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]   out_data_ff;
   logic               out_last_ff;

   logic               advance;
   logic [PIX_W-1:0]   upper_eff, middle_eff;
   logic [PIX_W-1:0]   up, down, left, right;
   logic [PIX_W+2:0]   pos_sum;
   logic [PIX_W+1:0]   neg_sum;
   logic [PIX_W+2:0]   diff;
   logic [PIX_W-1:0]   result;

   assign advance    = s1_valid_ff && (!s1_ff.emit || !out_valid_ff || rsp_tready);
   assign stage_free = !s1_valid_ff || advance;

   // the request just ahead wrote this column in the same cycle as our read
   assign upper_eff  = byp_ff ? byp_upper_ff : upper_q;
   assign middle_eff = byp_ff ? byp_middle_ff : middle_q;

   assign wr_en     = advance;
   assign wr_addr   = s1_addr_ff;
   assign wr_upper  = middle_eff;
   assign wr_middle = s1_ff.pix;

   // window after the shift: centre column is the previous newest column
   assign up    = s1_ff.up_ok ? c2_top_ff : '0;
   assign down  = s1_ff.down_ok ? c2_bot_ff : '0;
   assign left  = s1_ff.left_ok ? c1_mid_ff : '0;
   assign right = s1_ff.right_ok ? middle_eff : '0;

   always_comb begin
      pos_sum = (PIX_W+3)'(up) + (PIX_W+3)'(down) + (PIX_W+3)'(left)
              + (PIX_W+3)'(right) + (PIX_W+3)'(bias);
      neg_sum = {c2_mid_ff, 2'b00};
      diff    = pos_sum - (PIX_W+3)'(neg_sum);
      if (pos_sum < (PIX_W+3)'(neg_sum)) begin
         result = '0;
      end else if (diff > (PIX_W+3)'({PIX_W{1'b1}})) begin
         result = '1;
      end else begin
         result = diff[PIX_W-1:0];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      byp_in = byp_ff;
      if (load) begin
         byp_in = advance && (s1_addr_ff == addr);
      end
      out_valid_in = out_valid_ff;
      if (advance && s1_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         byp_ff       <= byp_in;
         out_valid_ff <= out_valid_in;
      end
      if (load) begin
         s1_ff         <= stage;
         s1_addr_ff    <= addr;
         byp_upper_ff  <= middle_eff;
         byp_middle_ff <= s1_ff.pix;
      end
      if (advance) begin
         c1_mid_ff <= c2_mid_ff;
         c2_top_ff <= upper_eff;
         c2_mid_ff <= middle_eff;
         c2_bot_ff <= s1_ff.pix;
      end
      if (advance && s1_ff.emit) begin
         out_data_ff <= result;
         out_last_ff <= s1_ff.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ hw/rtl/laplacian_3x3_edge_filter_top.sv @@
// top level of the four-neighbour 3x3 laplacian edge filter
//
// req_* carries 8-bit luma pixels in raster order; req_tuser high marks a flush
// request that carries no pixel. rsp_* returns one clamped laplacian-plus-bias
// value per pixel, with rsp_tlast on the last pixel of the frame. Pixels outside
// the frame count as zero. csr_* writes line_width (0), frame_height (1), bias (2).
// The result of a pixel is produced by the request one line plus one pixel later
// in the stream; line_width + 1 flush requests drain the end of a frame.
// That result passes the window stage register, then the output register, to rsp.
// One request is taken every clock while req_tready is high; the two line
// buffers are memories with one write and one read port, so each request reads
// and writes one column. After reset, and after each write of line_width or
// frame_height, req_tready is low while the frame totals and the output
// position are recomputed: two multiply steps and a bit-serial divide. Reset
// empties the pipeline and returns the registers to 352, 288 and 127. When
// rsp_tready is low the output register holds its result and requests are still
// taken until the window stage also holds a result, then req_tready drops.
module laplacian_3x3_edge_filter_top #(
   parameter int MAX_WIDTH  = lap_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lap_pkg::MAX_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [lap_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lap_pkg::CFG_W-1:0]      csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lap_pkg::PIX_W-1:0]      req_tdata,   // pixel
   input  logic                           req_tuser,   // flush
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lap_pkg::PIX_W-1:0]      rsp_tdata,   // filtered
   output logic                           rsp_tlast
);

   import lap_pkg::*;

   localparam int ADDR_W = $clog2(MAX_WIDTH);

   logic               stage_free;
   logic               load;
   lap_stage_type      stage;
   logic [ADDR_W-1:0]  rd_addr;
   logic [BIAS_W-1:0]  bias;
   logic [PIX_W-1:0]   upper_q, middle_q;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [PIX_W-1:0]   wr_upper, wr_middle;

   lap_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .stage_free (stage_free),
      .load       (load),
      .stage      (stage),
      .rd_addr    (rd_addr),
      .bias       (bias)
   );

   lap_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_upper),
      .rd_en   (load),
      .rd_addr (rd_addr),
      .rd_data (upper_q)
   );

   lap_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_middle),
      .rd_en   (load),
      .rd_addr (rd_addr),
      .rd_data (middle_q)
   );

   lap_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .stage      (stage),
      .addr       (rd_addr),
      .bias       (bias),
      .upper_q    (upper_q),
      .middle_q   (middle_q),
      .stage_free (stage_free),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_upper   (wr_upper),
      .wr_middle  (wr_middle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ tb/tb_laplacian_3x3_edge_filter_top.sv @@
// self-checking testbench of the four-neighbour 3x3 laplacian edge filter
module tb_laplacian_3x3_edge_filter_top;
   import lap_pkg::*;

   localparam int LIMIT_TIME = 5_000_000;
   localparam int RANDOM_PIXELS = 120;
   localparam int CALM_PIXELS = 90;

   typedef struct packed {
      logic [PIX_W-1:0] filtered;
      logic             frame_end;
   } filtered_px_type;

   // running copy of the filter: line stores, window, frame position, registers
   class laplace_scoreboard_type;
      bit [PIX_W-1:0]  upper_row [MAX_WIDTH_DEF];
      bit [PIX_W-1:0]  middle_row [MAX_WIDTH_DEF];
      bit [PIX_W-1:0]  win [3][3];    // [column old..new][top, middle, bottom]
      int unsigned     col_pos = 0;
      int unsigned     row_pos = 0;
      int unsigned     out_pos = 0;
      bit [CFG_W-1:0]  width_reg = LINE_WIDTH_RST;
      bit [CFG_W-1:0]  height_reg = FRAME_HEIGHT_RST;
      bit [BIAS_W-1:0] bias_reg = BIAS_RST;
      filtered_px_type pending_px [$];
      int unsigned     frames_closed = 0;
      int unsigned     checked = 0;
      int unsigned     errors = 0;

      function int unsigned dim_used(bit [CFG_W-1:0] raw, int unsigned cap);
         int unsigned v;
         v = raw;
         if (v > cap) v = cap;
         return (v == 0) ? 1 : v;
      endfunction

      function void set_reg(logic [CSR_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            CSR_LINE_WIDTH:   width_reg = val;
            CSR_FRAME_HEIGHT: height_reg = val;
            CSR_BIAS:         bias_reg = val[BIAS_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pixels_due();
         int unsigned w, h, t;
         w = dim_used(width_reg, MAX_WIDTH_DEF);
         h = dim_used(height_reg, MAX_HEIGHT_DEF);
         t = row_pos * w + col_pos;
         return (t < w * h) ? w * h - t : 0;
      endfunction

      function void push_pixel(logic [PIX_W-1:0] pix, logic flush);
         int unsigned w, h, total, t, c, p, pr, pc;
         int          acc;
         bit [PIX_W-1:0] fresh;
         filtered_px_type res;
         w = dim_used(width_reg, MAX_WIDTH_DEF);
         h = dim_used(height_reg, MAX_HEIGHT_DEF);
         total = w * h;
         t = row_pos * w + col_pos;
         // flush is dropped while pixels of the frame are still due
         if (flush && t < total) return;
         fresh = (t >= total) ? '0 : pix;
         c = col_pos % MAX_WIDTH_DEF;
         for (int k = 0; k < 3; k++) begin
            win[0][k] = win[1][k];
            win[1][k] = win[2][k];
         end
         win[2][0] = upper_row[c];
         win[2][1] = middle_row[c];
         win[2][2] = fresh;
         upper_row[c] = middle_row[c];
         middle_row[c] = fresh;
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1) & 10'h3FF;
         end
         if (t < w + 1) return;
         p = out_pos;
         pr = p / w;
         pc = p % w;
         acc = int'(bias_reg) - 4 * int'(win[1][1]);
         if (pr != 0) acc += win[1][0];
         if (pr + 1 < h) acc += win[1][2];
         if (pc != 0) acc += win[0][1];
         if (pc + 1 < w) acc += win[2][1];
         if (acc < 0) acc = 0;
         if (acc > 255) acc = 255;
         res.filtered = acc[PIX_W-1:0];
         res.frame_end = (p + 1 >= total);
         pending_px.push_back(res);
         if (res.frame_end) begin
            col_pos = 0;
            row_pos = 0;
            out_pos = 0;
            frames_closed++;
         end else begin
            out_pos = (p + 1) & 18'h3FFFF;
         end
      endfunction

      function void check_pixel(logic [PIX_W-1:0] filtered, logic frame_end);
         filtered_px_type want;
         if (pending_px.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: filtered=%0d last=%b",
                     $time, filtered, frame_end);
            return;
         end
         want = pending_px.pop_front();
         checked++;
         if (filtered !== want.filtered || frame_end !== want.frame_end) begin
            errors++;
            $display("%0t: result %0d: expected filtered=%0d last=%b,",
                     $time, checked, want.filtered, want.frame_end,
                     " got filtered=%0d last=%b", filtered, frame_end);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CFG_W-1:0]      csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata = '0;   // pixel
   logic                  req_tuser = 1'b0; // flush
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIX_W-1:0]      rsp_tdata;        // filtered
   logic                  rsp_tlast;

   laplace_scoreboard_type sb = new;
   bit                calm = 1'b0;
   int unsigned       requests_sent = 0;
   int unsigned       random_pixels = 0;
   int unsigned       reg_writes = 0;

   laplacian_3x3_edge_filter_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tlast);
   end

   // receiver: short random stalls, quiet stretches, one long hold-off
   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned span;
      bit          held;
      bit          stalls_on;
      stall_left = 0;
      span = 0;
      held = 1'b0;
      stalls_on = 1'b1;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         span++;
         if (span % 100 == 0) stalls_on = ($urandom_range(0, 2) != 0);
         if (stall_left > 0) begin
            stall_left--;
         end else if (!held && sb.checked >= 60) begin
            // long hold so the window stage fills and req_tready drops
            held = 1'b1;
            stall_left = 200;
         end else if (!calm && stalls_on && $urandom_range(0, 99) < 20) begin
            stall_left = $urandom_range(1, 5);
         end
         rsp_tready <= (stall_left == 0);
      end
   end

   task automatic offer(input logic [PIX_W-1:0] pix, input logic flush);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tuser <= flush;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      sb.push_pixel(pix, flush);
      requests_sent++;
   endtask

   task automatic pause_req(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic maybe_pause(input int unsigned pct);
      if (!calm && $urandom_range(0, 99) < pct) pause_req($urandom_range(1, 5));
   endtask

   // wait until every expected pixel is out, plus the pipeline latency
   task automatic settle();
      pause_req(1);
      while (sb.pending_px.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
      reg_writes++;
   endtask

   // remaining pixels of the frame with stray flushes, then drain until frame_end
   task automatic run_frame(input int unsigned gap_pct, input int unsigned noise_pct,
                            input bit counted);
      int unsigned due;
      int unsigned closed_at;
      due = sb.pixels_due();
      closed_at = sb.frames_closed;
      for (int k = 0; k < due; k++) begin
         maybe_pause(gap_pct);
         if ($urandom_range(0, 99) < noise_pct) offer(8'($urandom_range(0, 255)), 1'b1);
         offer(8'($urandom_range(0, 255)), 1'b0);
         if (counted) random_pixels++;
      end
      // a pixel after the frame is complete drains like a flush
      while (sb.frames_closed == closed_at) begin
         maybe_pause(gap_pct);
         offer(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
      end
   endtask

   initial begin : stimulus
      logic [PIX_W-1:0] checker_px [9];
      int unsigned      pick;
      int unsigned      gap_pct;
      checker_px = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (!req_tready) @(posedge clock);

      // flushes before any pixel of a frame are dropped
      offer(8'd17, 1'b1);
      offer(8'd255, 1'b1);
      settle();
      write_reg(CSR_LINE_WIDTH, 10'd3);
      write_reg(CSR_FRAME_HEIGHT, 10'd3);

      // checkerboard clamps both ways; stray flush mid-frame, pixels as drain
      for (int k = 0; k < 9; k++) begin
         offer(checker_px[k], 1'b0);
         if (k == 4) offer(8'd99, 1'b1);
      end
      offer(8'd200, 1'b0);
      offer(8'd0, 1'b1);
      offer(8'd255, 1'b0);
      offer(8'd0, 1'b1);
      settle();

      // size change in the middle of a frame, after two full lines and one pixel
      write_reg(CSR_LINE_WIDTH, 10'd4);
      write_reg(CSR_BIAS, 10'd0);
      for (int k = 0; k < 9; k++) offer(8'($urandom_range(0, 255)), 1'b0);
      settle();
      write_reg(CSR_LINE_WIDTH, 10'd3);
      write_reg(CSR_FRAME_HEIGHT, 10'd4);
      write_reg(CSR_BIAS, 10'd255);
      run_frame(0, 0, 1'b0);
      settle();

      // out-of-range sizes clamp: one column of 512 lines
      write_reg(CSR_LINE_WIDTH, 10'd0);
      write_reg(CSR_FRAME_HEIGHT, 10'd1023);
      write_reg(CSR_BIAS, 10'd128);
      run_frame(20, 5, 1'b0);

      while (random_pixels < RANDOM_PIXELS) begin
         if (random_pixels >= CALM_PIXELS) calm = 1'b1;
         if (!calm && $urandom_range(0, 99) < 40) begin
            settle();
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 1))
               write_reg(CSR_LINE_WIDTH,
                         10'(pick < 25 ? $urandom_range(9, 40) : $urandom_range(0, 8)));
            if ($urandom_range(0, 1))
               write_reg(CSR_FRAME_HEIGHT, 10'($urandom_range(0, 6)));
            if ($urandom_range(0, 1)) write_reg(CSR_BIAS, 10'($urandom_range(0, 1023)));
         end
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 15;
            default: gap_pct = 40;
         endcase
         run_frame(gap_pct, 8, 1'b1);
      end

      settle();
      repeat (20) @(posedge clock);
      if (sb.pending_px.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sb.pending_px.size());
         sb.errors++;
      end
      $display("covered %0d requests and %0d register writes over %0d frames,",
               requests_sent, reg_writes, sb.frames_closed);
      $display("with %0d filtered pixels checked and %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #LIMIT_TIME;
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending_px.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
